// File: rtl/core/scpa_pkg.sv
// Types, constants and arithmetic helpers for the sine/cosine polynomial approximator.
`default_nettype none

package scpa_pkg;

    localparam int VW         = 40;
    localparam int NUM_STAGES = 10;

    typedef logic signed [31:0]   t_word;
    typedef logic signed [VW-1:0] t_val;

    localparam logic [31:0] INV_TWO_PI_Q32  = 32'd683565091;
    localparam logic [29:0] INV_HALF_PI_Q30 = 30'd683565198;
    localparam t_val        TWO_PI_Q30      = 40'sd6746518852;
    localparam t_val        HALF_PI_Q30     = 40'sd1686629706;

    localparam t_val COEF_S0 = 40'sd8619999;
    localparam t_val COEF_S1 = -40'sd178892904;
    localparam t_val COEF_C0 = -40'sd1408749;
    localparam t_val COEF_C1 = 40'sd44659070;
    localparam t_val COEF_C2 = -40'sd536845142;
    localparam t_val COEF_C3 = 40'sd1073739677;

    // Q.30 product on magnitudes, round half away from zero, operands cut to 32 bits
    function automatic t_val q30_mul(input t_val a, input t_val b);
        logic        neg;
        logic [VW-1:0] ua;
        logic [VW-1:0] ub;
        logic [63:0] prod;
        logic [33:0] pm;
        begin
            neg  = a[VW-1] ^ b[VW-1];
            ua   = a[VW-1] ? (~a + 1'b1) : a;
            ub   = b[VW-1] ? (~b + 1'b1) : b;
            prod = 64'(ua[31:0]) * 64'(ub[31:0]) + 64'd536870912;
            pm   = prod[63:30];
            q30_mul = neg ? -t_val'(pm) : t_val'(pm);
        end
    endfunction

    function automatic t_word sat32(input t_val v);
        begin
            if (v > t_val'(32'sh7fffffff)) begin
                sat32 = 32'sh7fffffff;
            end else if (v < -t_val'(41'sh080000000)) begin
                sat32 = 32'sh80000000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sincos_poly_approx.sv
// Ten stages; o_valid is the valid bit of stage 9. Throughput while i_ready is high:
// one angle per cycle; stages 0-3 take the magnitude, turns, reduction and
// quadrant, stage 4 the offset, stages 5-8 the polynomials, stage 9 sign and saturation.
// Each stage moves when it is empty or the stage after it moves, so bubbles close up
// and a stalled output still lets the earlier stages fill.
// Reset (i_rst_n low, synchronous) clears the stage valid bits; data registers are not reset.
`default_nettype none

module sincos_poly_approx (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire scpa_pkg::t_word i_angle,
    output logic               o_valid,
    input  wire logic          i_ready,
    output scpa_pkg::t_word    o_sine,
    output scpa_pkg::t_word    o_cosine
);
    import scpa_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES:0]   adv;

    // stage registers
    logic        r_neg0, r_neg1, r_neg2, r_neg3;
    logic [31:0] r_mag0, r_mag1;
    logic [4:0]  r_n1;
    logic [33:0] r_r2, r_r3;
    logic [1:0]  r_q3;
    logic        r_ns4, r_ns5, r_ns6, r_ns7, r_ns8;
    logic        r_nc4, r_nc5, r_nc6, r_nc7, r_nc8;
    t_val        r_t4, r_u4, r_t5, r_t6;
    t_val        r_sx5, r_cx5, r_cx6, r_cx7;
    t_val        r_sp6, r_sxt6, r_cp6;
    t_val        r_sp7, r_cp7, r_sp8, r_cp8;
    t_word       r_sine, r_cosine;

    // next values
    logic [31:0] n_mag;
    logic [60:0] prod1;
    logic [4:0]  n_n;
    t_val        red;
    logic [33:0] n_r;
    logic [63:0] prod3;
    logic [3:0]  qfull;
    logic [1:0]  n_q;
    t_val        mx;
    t_val        n_t, n_u;
    logic        n_ns, n_nc;
    t_val        n_sx, n_cx;
    t_val        n_sp6, n_sxt6, n_cp6;
    t_val        n_sp7, n_cp7, n_cp8;
    t_val        sfin, cfin;

    always_comb begin
        adv[NUM_STAGES] = i_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign n_vld   = {r_vld[NUM_STAGES-2:0], i_valid};
    assign o_ready = adv[0];

    always_comb begin
        n_mag = i_angle[31] ? (~i_angle + 1'b1) : i_angle;

        prod1 = 61'(r_mag0) * 61'(INV_TWO_PI_Q32);
        n_n   = prod1[60:56];

        red = t_val'({r_mag1, 6'b000000}) - t_val'(40'(r_n1) * TWO_PI_Q30);
        n_r = red[VW-1] ? '0 : red[33:0];

        prod3 = 64'(r_r2) * 64'(INV_HALF_PI_Q30);
        qfull = prod3[63:60];
        n_q   = (qfull > 4'd3) ? 2'd3 : qfull[1:0];

        mx   = t_val'(r_r3) - t_val'(40'(r_q3) * HALF_PI_Q30);
        n_t  = r_q3[0] ? (HALF_PI_Q30 - mx) : mx;
        n_u  = r_q3[0] ? (mx - HALF_PI_Q30) : mx;
        n_ns = r_neg3 ^ r_q3[1];
        n_nc = r_q3[0] ^ r_q3[1];

        n_sx = q30_mul(r_t4, r_t4);
        n_cx = q30_mul(r_u4, r_u4);

        n_sp6  = q30_mul(COEF_S0, r_sx5) + COEF_S1;
        n_sxt6 = q30_mul(r_sx5, r_t5);
        n_cp6  = q30_mul(COEF_C0, r_cx5) + COEF_C1;

        n_sp7 = q30_mul(r_sp6, r_sxt6) + r_t6;
        n_cp7 = q30_mul(r_cp6, r_cx6) + COEF_C2;

        n_cp8 = q30_mul(r_cp7, r_cx7) + COEF_C3;

        sfin = r_ns8 ? -r_sp8 : r_sp8;
        cfin = r_nc8 ? -r_cp8 : r_cp8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_neg0 <= i_angle[31];
            r_mag0 <= n_mag;
        end
        if (adv[1]) begin
            r_neg1 <= r_neg0;
            r_mag1 <= r_mag0;
            r_n1   <= n_n;
        end
        if (adv[2]) begin
            r_neg2 <= r_neg1;
            r_r2   <= n_r;
        end
        if (adv[3]) begin
            r_neg3 <= r_neg2;
            r_r3   <= r_r2;
            r_q3   <= n_q;
        end
        if (adv[4]) begin
            r_t4  <= n_t;
            r_u4  <= n_u;
            r_ns4 <= n_ns;
            r_nc4 <= n_nc;
        end
        if (adv[5]) begin
            r_t5  <= r_t4;
            r_sx5 <= n_sx;
            r_cx5 <= n_cx;
            r_ns5 <= r_ns4;
            r_nc5 <= r_nc4;
        end
        if (adv[6]) begin
            r_t6   <= r_t5;
            r_sp6  <= n_sp6;
            r_sxt6 <= n_sxt6;
            r_cp6  <= n_cp6;
            r_cx6  <= r_cx5;
            r_ns6  <= r_ns5;
            r_nc6  <= r_nc5;
        end
        if (adv[7]) begin
            r_sp7 <= n_sp7;
            r_cp7 <= n_cp7;
            r_cx7 <= r_cx6;
            r_ns7 <= r_ns6;
            r_nc7 <= r_nc6;
        end
        if (adv[8]) begin
            r_sp8 <= r_sp7;
            r_cp8 <= n_cp8;
            r_ns8 <= r_ns7;
            r_nc8 <= r_nc7;
        end
        if (adv[9]) begin
            r_sine   <= sat32(sfin);
            r_cosine <= sat32(cfin);
        end
    end

    assign o_valid  = r_vld[NUM_STAGES-1];
    assign o_sine   = r_sine;
    assign o_cosine = r_cosine;

`ifndef ASSERT_OFF
    // back-pressure at the input only when every stage holds a transaction
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> ((&r_vld) && !i_ready))
        else $error("input blocked with a free stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted transaction not captured");

    a_turns_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_n1 <= 5'd21))
        else $error("turn count out of range");

    a_reduced_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (t_val'(r_r3) < (TWO_PI_Q30 + TWO_PI_Q30)))
        else $error("reduced angle beyond two turns");
`endif

endmodule

`default_nettype wire
